>>> hw/rtl/lpht_pkg.sv
// Package for the linear probe hash table: widths, opcodes, status codes, hash constants.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
    localparam int Capacity  = 1024;
    localparam int IdxW      = $clog2(Capacity);
    localparam int SizeW     = 11;
    localparam int KeyW      = 64;
    localparam int ValW      = 64;
    localparam int CntW      = 11;
    localparam int CollW     = 32;
    localparam int HashW     = 32;
    localparam int MinSize   = 5;

    localparam logic [HashW-1:0] HashSeed = 32'd3323198485;
    localparam logic [HashW-1:0] HashMult = 32'd1540483477;
    localparam int HashShift = 15;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpDelete = 2'd1;
    localparam logic [1:0] OpSearch = 2'd2;

    localparam logic [2:0] StInserted = 3'd0;
    localparam logic [2:0] StUpdated  = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StDeleted  = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StFound    = 3'd5;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [KeyW-1:0] key_bytes;
        logic [ValW-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [ValW-1:0]  value_out;
        logic [CntW-1:0]  entry_count;
        logic [CollW-1:0] collision_total;
    } rsp_t;

    // Hash unit to probe engine handoff
    typedef struct packed {
        logic            valid;
        logic [IdxW-1:0] home;
    } home_t;
endpackage

>>> hw/rtl/lpht_if.sv
// Valid/ready channel interfaces for the hash table.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
interface lpht_req_if;
    import lpht_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lpht_rsp_if;
    import lpht_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lpht_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/linear_probe_hash_table.sv
// Linear probe hash table: top level with slot memories and probe engine.
// Depends on lpht_pkg, lpht_if, lpht_hash.
//
// Usage: requests enter on req (opcode, key_bytes, value_in), one result per
// request leaves on rsp (status, value_out, entry_count, collision_total).
// cfg writes table_size; write it only while the block is idle.
// One request is in work at a time. After acceptance the key is hashed a
// byte at a time (xor in, then multiply and mix), the key end is found,
// the remainder is formed one quotient bit at a time, each probed slot
// takes a synchronous memory read and then a compare and write back, and
// the result is loaded. A scan stops once every slot of the table size in
// use has been probed; delete or search on an empty table and opcode 3
// skip probing.
// After reset a clearing pass over all 1024 slots marks every slot free;
// req.ready stays low meanwhile. Keys and values are memories without reset.
// A result waits in the output register while rsp.ready is low; the next
// request is taken the cycle after that result is taken.
`timescale 1ns / 1ps
module linear_probe_hash_table (
    input  logic clk,
    input  logic rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp,
    lpht_cfg_if.sink   cfg
);
    import lpht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [SizeW-1:0] tsize_reg;
    logic [SizeW-1:0] used_size;
    req_t             req_reg;
    logic [KeyW-1:0]  nkey;
    logic [IdxW-1:0]  ix_reg, ix_next;
    logic [SizeW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0]  live_reg, live_next;
    logic [CollW-1:0] coll_reg, coll_next;
    logic [IdxW-1:0]  clr_reg, clr_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;
    logic             load_rsp;
    logic             hash_start;
    home_t            home;
    logic [KeyW-1:0]  mem_key [Capacity];
    logic [ValW-1:0]  mem_val [Capacity];
    logic             mem_alive [Capacity];
    logic [KeyW-1:0]  rd_key_reg;
    logic [ValW-1:0]  rd_val_reg;
    logic             rd_alive_reg;
    logic             wr_key, wr_val, set_alive, clr_alive, clearing;
    logic             alive_we;
    logic [IdxW-1:0]  alive_addr;
    logic [IdxW-1:0]  ix_wrap;

    always_comb
    begin
        if (tsize_reg < SizeW'(MinSize))
            used_size = SizeW'(MinSize);
        else if (tsize_reg > SizeW'(Capacity))
            used_size = SizeW'(Capacity);
        else
            used_size = tsize_reg;
    end

    // keep bytes before the first zero byte
    always_comb
    begin
        logic stop;
        stop = 1'b0;
        nkey = '0;
        for (int i = 0; i < KeyW / 8; i++)
        begin
            if (req.payload.key_bytes[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                nkey[8*i +: 8] = req.payload.key_bytes[8*i +: 8];
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg.ready = 1'b1;
    assign hash_start = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tsize_reg <= SizeW'(MinSize);
        else if (cfg.valid)
            tsize_reg <= cfg.data;
    end

    lpht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (nkey),
        .size  (used_size),
        .home  (home)
    );

    assign ix_wrap  = ((SizeW'(ix_reg) + 1'b1) == used_size) ? '0 : ix_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        ix_next    = ix_reg;
        cnt_next   = cnt_reg;
        live_next  = live_reg;
        coll_next  = coll_reg;
        clr_next   = clr_reg;
        rsp_next   = rsp_reg;
        load_rsp   = 1'b0;
        wr_key     = 1'b0;
        wr_val     = 1'b0;
        set_alive  = 1'b0;
        clr_alive  = 1'b0;
        clearing   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clearing = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IdxW'(Capacity - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (hash_start)
                    state_next = S_HASH;
            end
            S_HASH:
            begin
                if (home.valid)
                begin
                    ix_next  = home.home;
                    cnt_next = '0;
                    rsp_next.status    = StNotFound;
                    rsp_next.value_out = '0;
                    if (req_reg.opcode == OpInsert)
                    begin
                        rsp_next.status = StFull;
                        state_next = S_READ;
                    end
                    else if ((req_reg.opcode == OpDelete || req_reg.opcode == OpSearch)
                             && live_reg != '0)
                        state_next = S_READ;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ:
            begin
                if (cnt_reg == used_size)
                    state_next = S_DONE;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_READ;
                cnt_next   = cnt_reg + 1'b1;
                ix_next    = ix_wrap;
                if (req_reg.opcode == OpInsert)
                begin
                    if (!rd_alive_reg)
                    begin
                        set_alive = 1'b1;
                        wr_key    = 1'b1;
                        wr_val    = 1'b1;
                        live_next = live_reg + 1'b1;
                        rsp_next.status = StInserted;
                        ix_next    = ix_reg;
                        state_next = S_DONE;
                    end
                    else if (rd_key_reg == req_reg.key_bytes)
                    begin
                        wr_val = 1'b1;
                        rsp_next.status = StUpdated;
                        ix_next    = ix_reg;
                        state_next = S_DONE;
                    end
                    else
                        coll_next = coll_reg + 1'b1;
                end
                else if (rd_alive_reg && rd_key_reg == req_reg.key_bytes)
                begin
                    ix_next    = ix_reg;
                    state_next = S_DONE;
                    if (req_reg.opcode == OpDelete)
                    begin
                        clr_alive = 1'b1;
                        live_next = live_reg - 1'b1;
                        rsp_next.status = StDeleted;
                    end
                    else
                    begin
                        rsp_next.status    = StFound;
                        rsp_next.value_out = rd_val_reg;
                    end
                end
            end
            S_DONE:
            begin
                rsp_next.entry_count     = live_reg;
                rsp_next.collision_total = coll_reg;
                load_rsp   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign alive_we   = set_alive || clr_alive || clearing;
    assign alive_addr = clearing ? clr_reg : ix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            live_reg      <= '0;
            coll_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            coll_reg  <= coll_next;
            clr_reg   <= clr_next;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ix_reg  <= ix_next;
        cnt_reg <= cnt_next;
        rsp_reg <= rsp_next;
        if (hash_start)
        begin
            req_reg.opcode    <= req.payload.opcode;
            req_reg.key_bytes <= nkey;
            req_reg.value_in  <= req.payload.value_in;
        end
    end

    // slot memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_key)
            mem_key[ix_reg] <= req_reg.key_bytes;
        if (wr_val)
            mem_val[ix_reg] <= req_reg.value_in;
        if (alive_we)
            mem_alive[alive_addr] <= set_alive;
        rd_key_reg   <= mem_key[ix_reg];
        rd_val_reg   <= mem_val[ix_reg];
        rd_alive_reg <= mem_alive[ix_reg];
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CntW'(Capacity))
        else $error("live count exceeds capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request accepted while busy");
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        set_alive |=> live_reg == $past(live_reg) + 1'b1)
        else $error("insert did not bump live count");
    a_single_slot_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(set_alive && clr_alive))
        else $error("slot set and cleared together");
endmodule

>>> hw/rtl/lpht_hash.sv
// Sequential key hash and home slot reduction, one key at a time: byte by byte, then a
// restoring remainder, one quotient bit per cycle. Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lpht_pkg::KeyW-1:0] key,
    input  logic [lpht_pkg::SizeW-1:0] size,
    output lpht_pkg::home_t           home
);
    import lpht_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;
    localparam logic [1:0] S_MOD  = 2'd3;
    localparam int ByteCntW = 4;
    localparam int BitCntW  = 6;

    logic [1:0]          state_reg, state_next;
    logic [KeyW-1:0]     key_reg, key_next;
    logic [ByteCntW-1:0] byte_reg, byte_next;
    logic [HashW-1:0]    h_reg, h_next;
    logic [HashW-1:0]    q_reg, q_next;
    logic [SizeW-1:0]    rem_reg, rem_next;
    logic [BitCntW-1:0]  bit_reg, bit_next;
    logic [SizeW-1:0]    size_reg, size_next;
    logic [7:0]          cur_byte;
    logic [SizeW:0]      trial;
    logic [63:0]         prod;

    assign cur_byte = key_reg[7:0];
    assign prod     = 64'(h_reg) * 64'(HashMult);
    assign trial    = {rem_reg, q_reg[HashW-1]};

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        byte_next  = byte_reg;
        h_next     = h_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        size_next  = size_reg;
        home.valid = 1'b0;
        home.home  = rem_reg[IdxW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    byte_next  = '0;
                    h_next     = HashSeed;
                    size_next  = size;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cur_byte == 8'd0 || byte_reg == ByteCntW'(KeyW / 8))
                begin
                    q_next     = h_reg;
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = S_MOD;
                end
                else
                begin
                    h_next     = h_reg ^ HashW'(cur_byte);
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                h_next     = prod[HashW-1:0] ^ (prod[HashW-1:0] >> HashShift);
                key_next   = key_reg >> 8;
                byte_next  = byte_reg + 1'b1;
                state_next = S_MUL;
            end
            S_MOD:
            begin
                if (trial >= {1'b0, size_reg})
                    rem_next = SizeW'(trial - {1'b0, size_reg});
                else
                    rem_next = trial[SizeW-1:0];
                q_next   = q_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BitCntW'(HashW))
                begin
                    rem_next   = rem_reg;
                    home.valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        byte_reg <= byte_next;
        h_reg    <= h_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        size_reg <= size_next;
    end
endmodule

>>> test/tb_top.sv
// Testbench for the linear probe hash table: directed and random insert, delete, search traffic.
// Depends on lpht_pkg, lpht_if and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps
module tb_top;
    import lpht_pkg::*;

    localparam int MaxCycles = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();
    lpht_cfg_if cfg_ch ();

    linear_probe_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    bit          alive_q [Capacity];
    logic [63:0] key_q   [Capacity];
    logic [63:0] val_q   [Capacity];
    int unsigned live_q;
    logic [31:0] coll_q;
    logic [10:0] size_reg;

    rsp_t expected_rsp [$];
    int   errors;
    int   checked;
    int   cycles;
    bit   no_idle;     // stretch with no idling on either side
    bit   done;

    // recent keys for well-formed traffic
    logic [63:0] key_pool [$];

    function automatic logic [63:0] norm_key(logic [63:0] k);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] hash_key(logic [63:0] k);
        logic [31:0] h;
        h = HashSeed;
        for (int i = 0; i < 8; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                break;
            h = h ^ {24'd0, k[8*i +: 8]};
            h = h * HashMult;
            h = h ^ (h >> HashShift);
        end
        return h;
    endfunction

    task automatic predict_op(input req_t r);
        logic [63:0] k;
        int unsigned sz, home, ix;
        rsp_t e;
        k = norm_key(r.key_bytes);
        sz = size_reg;
        if (sz < MinSize)
            sz = MinSize;
        if (sz > Capacity)
            sz = Capacity;
        home = hash_key(k) % sz;
        e.status = StNotFound;
        e.value_out = '0;
        if (r.opcode == OpInsert)
        begin
            e.status = StFull;
            for (int i = 0; i < sz; i++)
            begin
                ix = (home + i) % sz;
                if (!alive_q[ix])
                begin
                    alive_q[ix] = 1'b1;
                    key_q[ix] = k;
                    val_q[ix] = r.value_in;
                    live_q++;
                    e.status = StInserted;
                    break;
                end
                if (key_q[ix] == k)
                begin
                    val_q[ix] = r.value_in;
                    e.status = StUpdated;
                    break;
                end
                coll_q = coll_q + 1;
            end
        end
        else if ((r.opcode == OpDelete || r.opcode == OpSearch) && live_q != 0)
        begin
            for (int i = 0; i < sz; i++)
            begin
                ix = (home + i) % sz;
                if (alive_q[ix] && key_q[ix] == k)
                begin
                    if (r.opcode == OpDelete)
                    begin
                        alive_q[ix] = 1'b0;
                        live_q--;
                        e.status = StDeleted;
                    end
                    else
                    begin
                        e.value_out = val_q[ix];
                        e.status = StFound;
                    end
                    break;
                end
            end
        end
        e.entry_count = live_q[10:0];
        e.collision_total = coll_q;
        expected_rsp.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
        errors++;
    endtask

    // ---- response side ----
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("unexpected result", 64'd0, 64'd0);
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp_ch.payload.status !== e.status)
                    report_mismatch("status", 64'(rsp_ch.payload.status), 64'(e.status));
                if (rsp_ch.payload.value_out !== e.value_out)
                    report_mismatch("value_out", rsp_ch.payload.value_out, e.value_out);
                if (rsp_ch.payload.entry_count !== e.entry_count)
                    report_mismatch("entry_count", 64'(rsp_ch.payload.entry_count),
                                    64'(e.entry_count));
                if (rsp_ch.payload.collision_total !== e.collision_total)
                    report_mismatch("collision_total", 64'(rsp_ch.payload.collision_total),
                                    64'(e.collision_total));
            end
            checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MaxCycles)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_rsp.size());
            $display("FAIL linear_probe_hash_table");
            $finish;
        end
    end

    // ---- stimulus helpers ----
    task automatic send_op(input logic [1:0] op, input logic [63:0] k, input logic [63:0] v);
        req_t r;
        while (!no_idle && $urandom_range(99) < 30)
            @(posedge clk);
        r.opcode = op;
        r.key_bytes = k;
        r.value_in = v;
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_op(r);
        req_ch.valid <= 1'b0;
        // the block stays busy for many cycles after a transaction
        @(posedge clk);
    endtask

    task automatic drain;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * Capacity + 100) @(posedge clk);
    endtask

    task automatic write_size(input logic [10:0] s);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= s;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        size_reg = s;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // short keys with some zero bytes so strings end early
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int n;
        k = rand64();
        n = $urandom_range(8);
        if (n < 8)
            k[8*n +: 8] = 8'd0;
        return k;
    endfunction

    task automatic test_directed;
        // default size 5: empty table, empty key, fill to full, update, delete, opcode 3
        send_op(OpSearch, 64'h41, 64'd0);
        send_op(OpDelete, 64'h41, 64'd0);
        send_op(OpInsert, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(OpSearch, 64'hFF00_0000_0000_0000, 64'd0);
        send_op(OpInsert, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_op(OpInsert, 64'h0000_0000_0000_0041, 64'h1234);
        send_op(OpInsert, 64'hAA00_0000_0000_0042, 64'h5678);
        send_op(OpInsert, 64'h0102_0304_0506_0708, 64'hA5A5);
        send_op(OpInsert, 64'h99, 64'd7);
        send_op(OpInsert, 64'h41, 64'hDEAD);
        send_op(OpSearch, 64'h42, 64'd0);
        send_op(OpSearch, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_op(2'd3, 64'h41, 64'd0);
        send_op(OpDelete, 64'h42, 64'd0);
        send_op(OpDelete, 64'h42, 64'd0);
        send_op(OpSearch, 64'h41, 64'd0);
        send_op(OpInsert, 64'h7777, 64'h5555_AAAA_5555_AAAA);
    endtask

    task automatic run_random(input int count, input int key_span);
        logic [63:0] k;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            if (key_pool.size() == 0 || $urandom_range(99) < 35 || key_span == 0)
            begin
                k = rand_key();
                key_pool.push_back(k);
                if (key_pool.size() > key_span + 1)
                    void'(key_pool.pop_front());
            end
            else
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            sel = $urandom_range(99);
            if (sel < 45)
                send_op(OpInsert, k, rand64());
            else if (sel < 65)
                send_op(OpDelete, k, rand64());
            else if (sel < 97)
                send_op(OpSearch, k, rand64());
            else
                send_op(2'd3, k, rand64());
        end
    endtask

    task automatic test_size_sweep;
        // sizes shrink and grow with live entries, including out of range values
        write_size(11'd13);
        run_random(150, 20);
        write_size(11'd0);
        run_random(60, 10);
        write_size(11'd7);
        run_random(80, 12);
        write_size(11'd2047);
        run_random(40, 30);
        write_size(11'd1024);
        run_random(40, 30);
        write_size(11'd101);
        run_random(150, 60);
    endtask

    task automatic test_no_idle;
        no_idle = 1'b1;
        run_random(100, 15);
        no_idle = 1'b0;
    endtask

    task automatic test_pause_then_burst;
        run_random(20, 10);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        run_random(40, 10);
        write_size(11'd5);
        run_random(40, 6);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        size_reg = 11'd5;
        live_q = 0;
        coll_q = '0;
        errors = 0;
        checked = 0;
        cycles = 0;
        no_idle = 1'b0;
        for (int i = 0; i < Capacity; i++)
            alive_q[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_sweep();
        test_no_idle();
        test_pause_then_burst();
        drain();
        if (expected_rsp.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_rsp.size());
            errors++;
        end
        $display("covered: %0d results over table sizes 0..2047 with insert, delete, search",
                 checked);
        $display("and invalid opcodes, idle and back to back traffic; %0d mismatches", errors);
        if (errors == 0)
            $display("PASS linear_probe_hash_table");
        else
            $display("FAIL linear_probe_hash_table");
        $finish;
    end
endmodule
